/* src/bcrm_pkg.sv */
// Shared types, opcodes and register indexes of the bytecode register machine.
`timescale 1ns / 1ps

package bcrm_pkg;

   // Fixed machine geometry
   localparam int REG_COUNT    = 16;
   localparam int REG_ADDR_W   = 4;
   localparam int DATA_W       = 32;
   localparam int COST_W       = 8;
   localparam int NUM_COSTS    = 7;
   localparam int CSR_INDEX_W  = 3;
   localparam int OFFSET_W     = 8;
   localparam int LEN_W        = 3;
   localparam int OPCODE_W     = 8;
   localparam int NEXT_PC_W    = 16;
   localparam int REQ_DATA_W   = 88;
   localparam int RSP_DATA_W   = 88;

   // Defaults for top-level parameters
   localparam int PC_WIDTH_DEFAULT    = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Opcode bytes
   localparam logic [OPCODE_W-1:0] OP_RET       = 8'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD       = 8'd1;
   localparam logic [OPCODE_W-1:0] OP_SUB       = 8'd2;
   localparam logic [OPCODE_W-1:0] OP_MOV       = 8'd3;
   localparam logic [OPCODE_W-1:0] OP_MOVI      = 8'd4;
   localparam logic [OPCODE_W-1:0] OP_BRANCH    = 8'd5;
   localparam logic [OPCODE_W-1:0] OP_BRANCH_NZ = 8'd6;

   // Instruction byte lengths
   localparam logic [LEN_W-1:0] LEN_SHORT = 3'd1;
   localparam logic [LEN_W-1:0] LEN_PAIR  = 3'd2;
   localparam logic [LEN_W-1:0] LEN_IMM   = 3'd6;

   // Cost register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_COST_RETURN    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COST_ADD       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COST_SUB       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COST_MOV       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COST_MOVI      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_COST_BRANCH    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_COST_BRANCH_NZ = 3'd6;

   localparam logic [COST_W-1:0] COST_RESET = 8'd1;

   // Decoded operation class
   typedef enum logic [3:0] {
      KIND_START     = 4'd0,
      KIND_RETURN    = 4'd1,
      KIND_ADD       = 4'd2,
      KIND_SUB       = 4'd3,
      KIND_MOV       = 4'd4,
      KIND_MOVI      = 4'd5,
      KIND_BRANCH    = 4'd6,
      KIND_BRANCH_NZ = 4'd7,
      KIND_ILLEGAL   = 4'd8
   } kind_type;

   // Decoded word handed from the front end to the execute stage
   typedef struct packed {
      kind_type                    kind;
      logic [REG_ADDR_W-1:0]       dst;
      logic [REG_ADDR_W-1:0]       src;
      logic [DATA_W-1:0]           value;   // start parameter or immediate
      logic [COST_W-1:0]           cost;
      logic [LEN_W-1:0]            len;
      logic signed [OFFSET_W-1:0]  offset;
   } op_type;

   // Queue status seen by both ends
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

/* src/bytecode_register_machine_exec.sv */
// Top level of the bytecode register machine execute block.
// Path: an accepted request word enters the queue, then its operands are read into
// the execute stage, which loads the result register when it is free or draining.
// Throughput: one word per cycle while rsp_tready is high, set by the single execute
// stage that reads operands with a same-edge bypass from the register file write port.
// Reset: synchronous, clears registers, flags, pc, cycle total, queue; costs become 1.
`timescale 1ns / 1ps

module bytecode_register_machine_exec
   import bcrm_pkg::*;
#(
   parameter int PC_WIDTH    = PC_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // req_tdata: start_param[31:0], opcode[39:32], dest_reg[43:40], src_reg[47:44],
   //            immediate[79:48], branch_offset[87:80]
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: action[0]
   input  logic                    req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // rsp_tdata: next_pc[15:0], halted[16], illegal[17], result_value[49:18],
   //            cycle_total[81:50], negative[82], zero pad[87:83]
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [COST_W-1:0]       csr_wdata
);

   qstat_type q_status;
   logic      q_push, q_pop;
   op_type    q_data, q_head;

   bcrm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_data     (q_data)
   );

   bcrm_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   bcrm_exec #(
      .PC_WIDTH (PC_WIDTH)
   ) u_exec (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Reset leaves no word in flight
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && q_status.empty))
      else $error("word in flight after reset");

   // Never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("queue overflow");

   // Never pop an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("queue underflow");

   // An illegal opcode always halts
   a_illegal_halts: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[17]) |-> rsp_tdata[16])
      else $error("illegal result without halt");

endmodule

/* src/bcrm_front.sv */
// Front end: takes request words and cost writes, decodes into queue entries.
`timescale 1ns / 1ps

module bcrm_front
   import bcrm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // req_tdata: start_param[31:0], opcode[39:32], dest_reg[43:40], src_reg[47:44],
   //            immediate[79:48], branch_offset[87:80]
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: action[0]
   input  logic                    req_tuser,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [COST_W-1:0]       csr_wdata,
   input  qstat_type               q_status,
   output logic                    q_push,
   output op_type                  q_data
);

   logic [COST_W-1:0]   cost_ff [NUM_COSTS];
   logic [OPCODE_W-1:0] opcode;

   // Cost registers: accept every write, ignore indexes past the list
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COSTS; i++) cost_ff[i] <= COST_RESET;
      end else if (csr_valid && csr_ready &&
                   (32'(csr_index) < 32'(NUM_COSTS))) begin
         cost_ff[csr_index] <= csr_wdata;
      end
   end

   // Push straight into the queue while it has room
   assign req_tready = !q_status.full;
   assign q_push     = req_tvalid && req_tready;
   assign opcode     = req_tdata[39:32];

   // Classify the word
   always_comb begin
      q_data.dst    = req_tdata[43:40];
      q_data.src    = req_tdata[47:44];
      q_data.offset = req_tdata[87:80];
      q_data.value  = req_tdata[79:48];
      q_data.cost   = '0;
      q_data.len    = LEN_SHORT;
      q_data.kind   = KIND_ILLEGAL;
      if (req_tuser) begin
         q_data.kind  = KIND_START;
         q_data.value = req_tdata[31:0];
      end else begin
         if (opcode < OPCODE_W'(NUM_COSTS)) begin
            q_data.cost = cost_ff[CSR_INDEX_W'(opcode)];
         end
         case (opcode)
            OP_RET: begin
               q_data.kind = KIND_RETURN;
            end
            OP_ADD: begin
               q_data.kind = KIND_ADD;
               q_data.len  = LEN_PAIR;
            end
            OP_SUB: begin
               q_data.kind = KIND_SUB;
               q_data.len  = LEN_PAIR;
            end
            OP_MOV: begin
               q_data.kind = KIND_MOV;
               q_data.len  = LEN_PAIR;
            end
            OP_MOVI: begin
               q_data.kind = KIND_MOVI;
               q_data.len  = LEN_IMM;
            end
            OP_BRANCH: begin
               q_data.kind = KIND_BRANCH;
               q_data.len  = LEN_PAIR;
            end
            OP_BRANCH_NZ: begin
               q_data.kind = KIND_BRANCH_NZ;
               q_data.len  = LEN_PAIR;
            end
            default: begin
               q_data.kind = KIND_ILLEGAL;
            end
         endcase
      end
   end

endmodule

/* src/bcrm_queue.sv */
// Short queue of decoded words between the front end and the execute stage.
`timescale 1ns / 1ps

module bcrm_queue
   import bcrm_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  op_type     push_data,
   input  logic       pop,
   output op_type     head,
   output qstat_type  status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   op_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign head          = slot_ff[rd_ptr_ff];
   assign status.full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty  = (count_ff == '0);

   // Store payload without reset
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

/* src/bcrm_exec.sv */
// Execute stage: register file, flags, pc, cycle total and result register.
`timescale 1ns / 1ps

module bcrm_exec
   import bcrm_pkg::*;
#(
   parameter int PC_WIDTH = PC_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  op_type                  q_head,
   input  qstat_type               q_status,
   output logic                    q_pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // rsp_tdata: next_pc[15:0], halted[16], illegal[17], result_value[49:18],
   //            cycle_total[81:50], negative[82], zero pad[87:83]
   output logic [RSP_DATA_W-1:0]   rsp_tdata
);

   // Register file storage and per-entry valid bits
   logic [DATA_W-1:0]     rf_mem_ff [REG_COUNT];
   logic [REG_COUNT-1:0]  rf_valid_ff;

   // Execute stage holding registers
   logic                  e_valid_ff;
   op_type                e_op_ff;
   logic [DATA_W-1:0]     a_ff, b_ff;
   logic                  zero_ff, neg_ff;
   logic [PC_WIDTH-1:0]   pc_ff;
   logic [DATA_W-1:0]     acc_ff, r0_ff;

   // Result register
   logic                  rsp_valid_ff;
   logic [NEXT_PC_W-1:0]  rsp_pc_ff;
   logic                  rsp_halt_ff, rsp_ill_ff, rsp_neg_ff;
   logic [DATA_W-1:0]     rsp_r0_ff, rsp_acc_ff;

   // Next values
   logic                  e_fire;
   logic                  w_en;
   logic [REG_ADDR_W-1:0] w_addr;
   logic [DATA_W-1:0]     w_data;
   logic                  set_flags, take;
   logic [DATA_W-1:0]     acc_in, r0_in;
   logic [PC_WIDTH-1:0]   pc_in;
   logic                  zero_in, neg_in, halt_in, ill_in;

   // Fire when the result register is free or drains this cycle
   assign e_fire = e_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign q_pop  = !q_status.empty && (!e_valid_ff || e_fire);

   // Work out the operation
   always_comb begin
      w_en      = 1'b0;
      w_addr    = e_op_ff.dst;
      w_data    = b_ff;
      set_flags = 1'b0;
      take      = 1'b0;
      halt_in   = 1'b0;
      ill_in    = 1'b0;
      case (e_op_ff.kind)
         KIND_START: begin
            w_en   = 1'b1;
            w_addr = '0;
            w_data = e_op_ff.value;
         end
         KIND_RETURN: begin
            halt_in = 1'b1;
         end
         KIND_ADD: begin
            w_en      = 1'b1;
            w_data    = a_ff + b_ff;
            set_flags = 1'b1;
         end
         KIND_SUB: begin
            w_en      = 1'b1;
            w_data    = a_ff - b_ff;
            set_flags = 1'b1;
         end
         KIND_MOV: begin
            w_en   = 1'b1;
            w_data = b_ff;
         end
         KIND_MOVI: begin
            w_en   = 1'b1;
            w_data = e_op_ff.value;
         end
         KIND_BRANCH: begin
            take = 1'b1;
         end
         KIND_BRANCH_NZ: begin
            take = !zero_ff;
         end
         default: begin
            halt_in = 1'b1;
            ill_in  = 1'b1;
         end
      endcase

      zero_in = set_flags ? (w_data == '0) : zero_ff;
      neg_in  = set_flags ? w_data[DATA_W-1] : neg_ff;
      r0_in   = (w_en && (w_addr == '0)) ? w_data : r0_ff;

      if (e_op_ff.kind == KIND_START) begin
         pc_in  = '0;
         acc_in = '0;
      end else begin
         pc_in  = pc_ff + PC_WIDTH'(e_op_ff.len) +
                  (take ? PC_WIDTH'(e_op_ff.offset) : '0);
         acc_in = acc_ff + DATA_W'(e_op_ff.cost);
      end
   end

   // Write the register file
   always_ff @(posedge clock) begin
      if (e_fire && w_en) rf_mem_ff[w_addr] <= w_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
      end else if (e_fire && w_en) begin
         rf_valid_ff[w_addr] <= 1'b1;
      end
   end

   // Read operands into the stage, bypassing the write of this same edge
   always_ff @(posedge clock) begin
      if (q_pop) begin
         e_op_ff <= q_head;
         if (e_fire && w_en && (w_addr == q_head.dst)) a_ff <= w_data;
         else a_ff <= rf_valid_ff[q_head.dst] ? rf_mem_ff[q_head.dst] : '0;
         if (e_fire && w_en && (w_addr == q_head.src)) b_ff <= w_data;
         else b_ff <= rf_valid_ff[q_head.src] ? rf_mem_ff[q_head.src] : '0;
      end
   end

   // Update machine state and stage occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         zero_ff    <= 1'b0;
         neg_ff     <= 1'b0;
         pc_ff      <= '0;
         acc_ff     <= '0;
         r0_ff      <= '0;
      end else begin
         if (q_pop) e_valid_ff <= 1'b1;
         else if (e_fire) e_valid_ff <= 1'b0;
         if (e_fire) begin
            zero_ff <= zero_in;
            neg_ff  <= neg_in;
            pc_ff   <= pc_in;
            acc_ff  <= acc_in;
            r0_ff   <= r0_in;
         end
      end
   end

   // Hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (e_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (e_fire) begin
         rsp_pc_ff   <= NEXT_PC_W'(pc_in);
         rsp_halt_ff <= halt_in;
         rsp_ill_ff  <= ill_in;
         rsp_r0_ff   <= r0_in;
         rsp_acc_ff  <= acc_in;
         rsp_neg_ff  <= neg_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_neg_ff, rsp_acc_ff, rsp_r0_ff,
                        rsp_ill_ff, rsp_halt_ff, rsp_pc_ff};

endmodule

/* verif/bcrm_exec_scoreboard.sv */
// Predictor and result scoreboard for the bytecode register machine execute block.
`timescale 1ns / 1ps

package bcrm_exec_check_pkg;
   import bcrm_pkg::*;

   // One expected result word, field by field
   typedef struct {
      logic [NEXT_PC_W-1:0] next_pc;
      logic                 halted;
      logic                 illegal;
      logic [DATA_W-1:0]    result_value;
      logic [DATA_W-1:0]    cycle_total;
      logic                 negative;
   } machine_outcome;

   class exec_scoreboard;
      // Machine copy kept in step with the block
      logic [DATA_W-1:0]           regs [REG_COUNT];
      logic                        z_flag;
      logic                        neg_flag;
      logic [PC_WIDTH_DEFAULT-1:0] pc;
      logic [DATA_W-1:0]           cycles;
      logic [COST_W-1:0]           cost [NUM_COSTS];

      machine_outcome awaited_states [$];
      int errors;
      int results_checked;
      int starts;
      int illegals;
      int ops_seen [NUM_COSTS];

      function new();
         foreach (regs[i]) regs[i] = '0;
         foreach (cost[i]) cost[i] = COST_RESET;
         foreach (ops_seen[i]) ops_seen[i] = 0;
         z_flag = 1'b0;
         neg_flag = 1'b0;
         pc = '0;
         cycles = '0;
         errors = 0;
         results_checked = 0;
         starts = 0;
         illegals = 0;
      endfunction

      function void set_cost(logic [CSR_INDEX_W-1:0] index, logic [COST_W-1:0] value);
         if (index < NUM_COSTS) cost[index] = value;
      endfunction

      // Advance the machine copy by one accepted request word and queue its result
      function void run_instruction(logic start, logic [REQ_DATA_W-1:0] word);
         logic [DATA_W-1:0]   param;
         logic [OPCODE_W-1:0] opc;
         logic [3:0]          dst;
         logic [3:0]          src;
         logic [DATA_W-1:0]   imm;
         logic [DATA_W-1:0]   off_ext;
         logic [DATA_W-1:0]   len;
         machine_outcome      o;
         param   = word[31:0];
         opc     = word[39:32];
         dst     = word[43:40];
         src     = word[47:44];
         imm     = word[79:48];
         off_ext = {{24{word[87]}}, word[87:80]};
         o.halted  = 1'b0;
         o.illegal = 1'b0;
         if (start) begin
            starts++;
            pc = '0;
            cycles = '0;
            regs[0] = param;
         end else if (opc > OP_BRANCH_NZ) begin
            illegals++;
            o.halted = 1'b1;
            o.illegal = 1'b1;
            pc = PC_WIDTH_DEFAULT'(pc + 1);
         end else begin
            ops_seen[opc]++;
            cycles = cycles + cost[opc];
            len = LEN_PAIR;
            case (opc)
               OP_RET: begin
                  o.halted = 1'b1;
                  len = LEN_SHORT;
               end
               OP_ADD: begin
                  regs[dst] = regs[dst] + regs[src];
                  z_flag = (regs[dst] == '0);
                  neg_flag = regs[dst][DATA_W-1];
               end
               OP_SUB: begin
                  regs[dst] = regs[dst] - regs[src];
                  z_flag = (regs[dst] == '0);
                  neg_flag = regs[dst][DATA_W-1];
               end
               OP_MOV:    regs[dst] = regs[src];
               OP_MOVI: begin
                  regs[dst] = imm;
                  len = LEN_IMM;
               end
               OP_BRANCH: len = LEN_PAIR + off_ext;
               default:   len = z_flag ? DATA_W'(LEN_PAIR) : LEN_PAIR + off_ext;
            endcase
            pc = PC_WIDTH_DEFAULT'(pc + len);
         end
         o.next_pc      = NEXT_PC_W'(pc);
         o.result_value = regs[0];
         o.cycle_total  = cycles;
         o.negative     = neg_flag;
         awaited_states.push_back(o);
      endfunction

      task flag_mismatch(string what);
         errors++;
         $display("mismatch at %0t: %s", $time, what);
      endtask

      task compare_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
         if (got !== want)
            flag_mismatch($sformatf("%s got 0x%0h expected 0x%0h (result %0d)",
                                    name, got, want, results_checked));
      endtask

      // Compare one accepted result word with the oldest expectation
      task check_result(logic [RSP_DATA_W-1:0] word);
         machine_outcome o;
         if (awaited_states.size() == 0) begin
            flag_mismatch($sformatf("unexpected result word 0x%0h", word));
            return;
         end
         o = awaited_states.pop_front();
         compare_field("next_pc", DATA_W'(word[15:0]), DATA_W'(o.next_pc));
         compare_field("halted", DATA_W'(word[16]), DATA_W'(o.halted));
         compare_field("illegal", DATA_W'(word[17]), DATA_W'(o.illegal));
         compare_field("result_value", word[49:18], o.result_value);
         compare_field("cycle_total", word[81:50], o.cycle_total);
         compare_field("negative", DATA_W'(word[82]), DATA_W'(o.negative));
         results_checked++;
      endtask
   endclass

endpackage

/* verif/bytecode_register_machine_exec_tb.sv */
// Self-checking testbench for the bytecode register machine execute block.
`timescale 1ns / 1ps

module bytecode_register_machine_exec_tb;
   import bcrm_pkg::*;
   import bcrm_exec_check_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 80;
   localparam int SETTLE_CYCLES  = 6;
   localparam int PHASE_ITEMS    = 136;

   localparam logic [OPCODE_W-1:0] OP_FIRST_ILLEGAL = OP_BRANCH_NZ + 8'd1;
   localparam logic [OPCODE_W-1:0] OP_MID_ILLEGAL   = 8'h80;
   localparam logic [OPCODE_W-1:0] OP_TOP_ILLEGAL   = 8'hff;

   localparam logic [CSR_INDEX_W-1:0] COST_INDEX [NUM_COSTS] = '{
      CSR_COST_RETURN, CSR_COST_ADD, CSR_COST_SUB, CSR_COST_MOV,
      CSR_COST_MOVI, CSR_COST_BRANCH, CSR_COST_BRANCH_NZ};

   typedef enum int {COSTS_ALL_MAX, COSTS_ALL_ZERO, COSTS_RANDOM, COSTS_EXTREME_MIX}
      cost_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // req_tdata: start_param, opcode, dest_reg, src_reg, immediate, branch_offset
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   // req_tuser: action
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // rsp_tdata: next_pc, halted, illegal, result_value, cycle_total, negative, pad
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [COST_W-1:0]      csr_wdata = '0;

   logic steady = 1'b0;     // no random gaps on either side while set
   int   hold_asked = 0;    // bumped to ask the receiver for a long hold-off
   int   cost_settings = 1;
   int   quiet_cycles = 0;

   exec_scoreboard board = new();

   bytecode_register_machine_exec dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h8000_0000;
         3: return 32'hffff_ffff;
         4: return 32'h0000_0001;
         default: return $urandom();
      endcase
   endfunction

   // Favor a few low registers so results feed later instructions
   function automatic logic [3:0] pick_reg();
      if ($urandom_range(0, 1) == 0) return 4'($urandom_range(0, 3));
      return 4'($urandom_range(0, 15));
   endfunction

   // Filler for fields an opcode ignores
   function automatic logic [3:0] any_reg();
      return 4'($urandom());
   endfunction

   function automatic logic [OFFSET_W-1:0] any_offset();
      return OFFSET_W'($urandom());
   endfunction

   function automatic logic [OPCODE_W-1:0] any_opcode();
      return OPCODE_W'($urandom());
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_request(
      logic [DATA_W-1:0] param, logic [OPCODE_W-1:0] opc, logic [3:0] dst,
      logic [3:0] src, logic [DATA_W-1:0] imm, logic [OFFSET_W-1:0] off);
      return {off, imm, src, dst, opc, param};
   endfunction

   // Offer one request word after a random gap and hold it until accepted
   task automatic send_word(logic start, logic [REQ_DATA_W-1:0] word);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= start;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      board.run_instruction(start, word);
   endtask

   task automatic send_start(logic [DATA_W-1:0] param);
      send_word(1'b1, pack_request(param, any_opcode(), any_reg(), any_reg(),
                                   $urandom(), any_offset()));
   endtask

   task automatic send_op(logic [OPCODE_W-1:0] opc, logic [3:0] dst, logic [3:0] src,
                          logic [DATA_W-1:0] imm, logic [OFFSET_W-1:0] off);
      send_word(1'b0, pack_request($urandom(), opc, dst, src, imm, off));
   endtask

   // Stop offering and wait for every outstanding result
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (board.awaited_states.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all seven cost registers back to back
   task automatic program_costs(cost_mode_type mode);
      logic [COST_W-1:0] value;
      for (int i = 0; i < NUM_COSTS; i++) begin
         case (mode)
            COSTS_ALL_MAX:  value = '1;
            COSTS_ALL_ZERO: value = '0;
            COSTS_RANDOM:   value = COST_W'($urandom());
            default:        value = ($urandom_range(0, 1) != 0) ? '1 : '0;
         endcase
         csr_valid <= 1'b1;
         csr_index <= COST_INDEX[i];
         csr_wdata <= value;
         do @(posedge clock); while (!csr_ready);
         board.set_cost(COST_INDEX[i], value);
      end
      csr_valid <= 1'b0;
      cost_settings++;
   endtask

   task automatic random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)
         send_start(pick_value());
      else if (r < 9)
         send_op(OPCODE_W'($urandom_range(OP_FIRST_ILLEGAL, OP_TOP_ILLEGAL)), any_reg(),
                 any_reg(), $urandom(), any_offset());
      else
         send_op(OPCODE_W'($urandom_range(OP_RET, OP_BRANCH_NZ)), pick_reg(), pick_reg(),
                 pick_value(), any_offset());
   endtask

   // One random phase, optionally with a steady stretch, a receiver hold-off or a pause
   task automatic run_random(int count, bit with_steady, bit with_hold, bit with_pause);
      for (int i = 0; i < count; i++) begin
         if (with_steady && i == 0) steady <= 1'b1;
         if (with_steady && i == 40) steady <= 1'b0;
         if (with_hold && i == count / 2) begin
            hold_asked <= hold_asked + 1;
            steady <= 1'b1;
         end
         if (with_hold && i == count / 2 + 40) steady <= 1'b0;
         if (with_pause && i == count / 2) drain_results();
         random_item();
      end
   endtask

   // Result side: check each accepted word, then pick the next ready value
   initial begin
      int stall_left;
      int hold_served;
      stall_left = 0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
         if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // End the run when nothing moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", quiet_cycles);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: flags, wrap, branch extremes, halts and illegal opcodes at reset costs
      send_start(32'h7fff_ffff);
      send_op(OP_MOVI, 4'd1, any_reg(), 32'h0000_0001, any_offset());
      send_op(OP_ADD, 4'd0, 4'd1, $urandom(), any_offset());
      send_op(OP_SUB, 4'd0, 4'd0, $urandom(), any_offset());
      send_op(OP_BRANCH_NZ, any_reg(), any_reg(), $urandom(), 8'h7f);
      send_op(OP_ADD, 4'd0, 4'd1, $urandom(), any_offset());
      send_op(OP_BRANCH_NZ, any_reg(), any_reg(), $urandom(), 8'h80);
      send_op(OP_BRANCH, any_reg(), any_reg(), $urandom(), 8'h7f);
      send_op(OP_BRANCH, any_reg(), any_reg(), $urandom(), 8'h80);
      send_start(32'h0000_0000);
      send_op(OP_BRANCH, any_reg(), any_reg(), $urandom(), 8'h80);
      send_op(OP_MOVI, 4'd15, any_reg(), 32'hffff_ffff, any_offset());
      send_op(OP_MOV, 4'd0, 4'd15, $urandom(), any_offset());
      send_op(OP_ADD, 4'd0, 4'd0, $urandom(), any_offset());
      send_op(OP_SUB, 4'd15, 4'd0, $urandom(), any_offset());
      send_op(OP_MOV, 4'd15, 4'd15, $urandom(), any_offset());
      send_op(OP_MOVI, 4'd0, any_reg(), 32'h8000_0000, any_offset());
      send_op(OP_RET, any_reg(), any_reg(), $urandom(), any_offset());
      send_op(OP_FIRST_ILLEGAL, any_reg(), any_reg(), $urandom(), any_offset());
      send_op(OP_MID_ILLEGAL, any_reg(), any_reg(), $urandom(), any_offset());
      send_op(OP_TOP_ILLEGAL, any_reg(), any_reg(), $urandom(), any_offset());
      send_op(OP_ADD, 4'd2, 4'd1, $urandom(), any_offset());
      send_start(32'h8000_0000);
      send_op(OP_BRANCH_NZ, any_reg(), any_reg(), $urandom(), 8'h80);

      // Random phases, each under a new cost setting written while idle
      drain_results();
      program_costs(COSTS_ALL_MAX);
      run_random(PHASE_ITEMS, 1'b0, 1'b0, 1'b0);
      drain_results();
      program_costs(COSTS_ALL_ZERO);
      run_random(PHASE_ITEMS, 1'b1, 1'b0, 1'b0);
      drain_results();
      program_costs(COSTS_RANDOM);
      run_random(PHASE_ITEMS, 1'b0, 1'b1, 1'b0);
      drain_results();
      program_costs(COSTS_EXTREME_MIX);
      run_random(PHASE_ITEMS, 1'b0, 1'b0, 1'b1);
      drain_results();
      program_costs(COSTS_RANDOM);
      run_random(PHASE_ITEMS, 1'b0, 1'b0, 1'b0);

      // Wind down: the watchdog bounds this wait
      drain_results();

      $display("covered %0d starts, %0d illegal opcodes, %0d results checked, %0d cost settings",
               board.starts, board.illegals, board.results_checked, cost_settings);
      $display("opcode mix ret/add/sub/mov/movi/br/bnz: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
               board.ops_seen[0], board.ops_seen[1], board.ops_seen[2], board.ops_seen[3],
               board.ops_seen[4], board.ops_seen[5], board.ops_seen[6]);
      if (board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", board.errors);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
